/* hw/rtl/tca_pkg.sv */
// Package for the tag-side XOR challenge authentication block.
// Opcode and reply codes, register indexes, payload types and word helpers.
// No dependencies.
package tca_pkg;

   localparam int unsigned WordWidth   = 16;
   localparam int unsigned OpWidth     = 3;
   localparam int unsigned KindWidth   = 2;
   localparam int unsigned CountWidth  = 2;
   localparam int unsigned CsrIdxWidth = 4;
   localparam int unsigned RotWidth    = 4;
   localparam int unsigned PopWidth    = 5;

   localparam logic [WordWidth-1:0] READER_BIAS = 16'h5555;

   typedef logic [WordWidth-1:0] word_type;

   typedef enum logic [OpWidth-1:0] {
      OP_REQUEST        = 3'd0,
      OP_VERIFY         = 3'd1,
      OP_READER_CHAL    = 3'd2,
      OP_MUTUAL_REQUEST = 3'd3,
      OP_PLAIN_REQUEST  = 3'd4
   } opcode_type;

   typedef enum logic [KindWidth-1:0] {
      KIND_WORDS   = 2'd0,
      KIND_SUCCESS = 2'd1,
      KIND_FAILURE = 2'd2
   } kind_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_XOR_KEY    = 4'd0,
      CSR_ADD_OFFSET = 4'd1
   } csr_idx_type;

   localparam logic [CountWidth-1:0] COUNT_NONE = 2'd0;
   localparam logic [CountWidth-1:0] COUNT_ONE  = 2'd1;
   localparam logic [CountWidth-1:0] COUNT_TWO  = 2'd2;

   typedef struct packed {
      logic [OpWidth-1:0] opcode;
      word_type           reader_word;
      word_type           fresh_random;
   } req_payload_type;

   typedef struct packed {
      logic [KindWidth-1:0]  reply_kind;
      word_type              first_word;
      word_type              second_word;
      logic [CountWidth-1:0] word_count;
   } rsp_payload_type;

   typedef struct packed {
      word_type xor_key;
      word_type add_offset;
   } key_cfg_type;

   typedef struct packed {
      logic     has_reply;
      logic     load_chal;
      word_type chal_in;
   } engine_ctl_type;

   function automatic logic [PopWidth-1:0] popcount16(input word_type v);
      logic [PopWidth-1:0] c;
      c = '0;
      for (int i = 0; i < WordWidth; i++) begin
         c = c + PopWidth'(v[i]);
      end
      return c;
   endfunction

   function automatic word_type rotl16(input word_type v, input logic [RotWidth-1:0] p);
      logic [2*WordWidth-1:0] d;
      d = {v, v} << p;
      return d[2*WordWidth-1:WordWidth];
   endfunction

endpackage

/* hw/rtl/tca_if.sv */
// Handshake channel interfaces: request, response and register write.
// Depends on tca_pkg.
interface tca_req_if
   import tca_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [OpWidth-1:0] opcode;
   word_type           reader_word;
   word_type           fresh_random;

   modport source (output valid, output opcode, output reader_word, output fresh_random,
                   input ready);
   modport sink   (input valid, input opcode, input reader_word, input fresh_random,
                   output ready);
endinterface

interface tca_rsp_if
   import tca_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [KindWidth-1:0]  reply_kind;
   word_type              first_word;
   word_type              second_word;
   logic [CountWidth-1:0] word_count;

   modport source (output valid, output reply_kind, output first_word, output second_word,
                   output word_count, input ready);
   modport sink   (input valid, input reply_kind, input first_word, input second_word,
                   input word_count, output ready);
endinterface

interface tca_csr_if
   import tca_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [CsrIdxWidth-1:0] index;
   word_type               data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/tca_csr.sv */
// Key and offset registers written through the register write channel.
// Depends on tca_pkg and tca_csr_if.
module tca_csr
   import tca_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   tca_csr_if.sink        csr_chan,
   output key_cfg_type    cfg
);

   word_type key_ff, key_in;
   word_type offset_ff, offset_in;
   logic     wr;

   assign csr_chan.ready = 1'b1;
   assign wr = csr_chan.valid;

   always_comb begin
      key_in    = key_ff;
      offset_in = offset_ff;
      if (wr && csr_chan.index == CSR_XOR_KEY) begin
         key_in = csr_chan.data;
      end
      if (wr && csr_chan.index == CSR_ADD_OFFSET) begin
         offset_in = csr_chan.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         offset_ff <= '0;
      end else begin
         key_ff    <= key_in;
         offset_ff <= offset_in;
      end
   end

   assign cfg.xor_key    = key_ff;
   assign cfg.add_offset = offset_ff;

endmodule

/* hw/rtl/tca_engine.sv */
// Single-pass command evaluation: popcount, rotates, offset add and compare.
// Depends on tca_pkg.
module tca_engine
   import tca_pkg::*;
(
   input  req_payload_type  req,
   input  word_type         chal,
   input  key_cfg_type      cfg,
   output rsp_payload_type  rsp,
   output engine_ctl_type   ctl
);

   logic [PopWidth-1:0] chal_pop;
   logic [PopWidth-1:0] rdr_pop;
   logic [RotWidth-1:0] chal_rot;
   logic [RotWidth-1:0] rdr_rot;
   word_type            rdr_r;
   word_type            rdr_answer;
   word_type            masked_rnd;
   logic                verify_ok;

   assign chal_pop   = popcount16(chal);
   assign chal_rot   = chal_pop[RotWidth-1:0];
   assign verify_ok  = (rotl16(cfg.xor_key, chal_rot) + cfg.add_offset)
                       == (req.reader_word ^ rotl16(chal, chal_rot));

   assign rdr_r      = (req.reader_word ^ cfg.xor_key) - READER_BIAS;
   assign rdr_pop    = popcount16(rdr_r);
   assign rdr_rot    = rdr_pop[RotWidth-1:0];
   assign rdr_answer = rotl16(rdr_r, rdr_rot)
                       ^ (rotl16(cfg.xor_key, rdr_rot) + cfg.add_offset);

   assign masked_rnd = (req.fresh_random + cfg.add_offset) ^ cfg.xor_key;

   always_comb begin
      rsp.reply_kind  = KIND_WORDS;
      rsp.first_word  = '0;
      rsp.second_word = '0;
      rsp.word_count  = COUNT_NONE;
      ctl.has_reply   = 1'b1;
      ctl.load_chal   = 1'b0;
      ctl.chal_in     = req.fresh_random;
      unique case (opcode_type'(req.opcode))
         OP_REQUEST: begin
            rsp.first_word = masked_rnd;
            rsp.word_count = COUNT_ONE;
            ctl.load_chal  = 1'b1;
         end
         OP_VERIFY: begin
            rsp.reply_kind = verify_ok ? KIND_SUCCESS : KIND_FAILURE;
         end
         OP_READER_CHAL: begin
            rsp.first_word = rdr_answer;
            rsp.word_count = COUNT_ONE;
         end
         OP_MUTUAL_REQUEST: begin
            rsp.first_word  = rdr_answer;
            rsp.second_word = masked_rnd;
            rsp.word_count  = COUNT_TWO;
            ctl.load_chal   = 1'b1;
         end
         OP_PLAIN_REQUEST: begin
            rsp.first_word = req.fresh_random;
            rsp.word_count = COUNT_ONE;
            ctl.load_chal  = 1'b1;
         end
         default: begin
            ctl.has_reply = 1'b0;
         end
      endcase
   end

endmodule

/* hw/rtl/tag_xor_challenge_auth.sv */
// Tag-side XOR challenge authentication, top level.
// A request passes the input register, then the response register, before its
// response is valid. One request per cycle unless stalled; the engine is a
// single combinational pass on 16-bit words. Unknown opcodes are dropped.
// Reset (synchronous): clears key, offset, tag challenge and both valid flags.
// Depends on tca_pkg, tca_if, tca_csr and tca_engine.
module tag_xor_challenge_auth
   import tca_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   tca_req_if.sink  req_chan,
   tca_rsp_if.source rsp_chan,
   tca_csr_if.sink  csr_chan
);

   key_cfg_type     cfg;
   req_payload_type s1_req_ff, s1_req_in;
   logic            s1_valid_ff, s1_valid_in;
   word_type        chal_ff, chal_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type eng_rsp;
   engine_ctl_type  eng_ctl;
   logic            s1_advance;
   logic            req_take;

   tca_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   tca_engine u_engine (
      .req  (s1_req_ff),
      .chal (chal_ff),
      .cfg  (cfg),
      .rsp  (eng_rsp),
      .ctl  (eng_ctl)
   );

   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (req_take) begin
         s1_valid_in            = 1'b1;
         s1_req_in.opcode       = req_chan.opcode;
         s1_req_in.reader_word  = req_chan.reader_word;
         s1_req_in.fresh_random = req_chan.fresh_random;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      chal_in      = chal_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_advance) begin
         if (eng_ctl.load_chal) begin
            chal_in = eng_ctl.chal_in;
         end
         if (eng_ctl.has_reply) begin
            rsp_in       = eng_rsp;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         chal_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         chal_ff      <= chal_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.reply_kind  = rsp_ff.reply_kind;
   assign rsp_chan.first_word  = rsp_ff.first_word;
   assign rsp_chan.second_word = rsp_ff.second_word;
   assign rsp_chan.word_count  = rsp_ff.word_count;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("response valid after reset");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while pipeline stalled");

   a_kind_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.reply_kind == KIND_WORDS) == (rsp_ff.word_count != COUNT_NONE)))
      else $error("reply kind and word count disagree");

   a_chal_holds: assert property (@(posedge clock) disable iff (reset)
      !s1_advance |=> $stable(chal_ff))
      else $error("tag challenge changed without a command");

endmodule
